### src/dcgh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcgh_pkg
// shared widths, status codes and stage records of the distance constraint
// gradient and hessian pipeline
// ----------------------------------------------------------------------------
package dcgh_pkg;

	localparam int CW      = 32;              // coordinate width
	localparam int FW      = 16;              // coordinate fraction bits
	localparam int NCRD    = 12;              // coordinates per item
	localparam int DW      = CW + 1;          // coordinate difference width
	localparam int SW      = 2 * DW;          // sum of squares width
	localparam int LW      = DW;              // length width
	localparam int DFB     = 30;              // direction fraction bits
	localparam int DIRW    = 32;              // direction field width
	localparam int DQW     = DFB + 1;         // direction magnitude width
	localparam int HMW     = 2 * DFB + 1;     // hessian numerator width
	localparam int AW      = HMW + 2 * FW - 2 * DFB;
	localparam int IN_DW   = ((NCRD * CW + 7) / 8) * 8;
	localparam int OUT_RAW = 3 * DIRW + 7 * CW;
	localparam int OUT_DW  = ((OUT_RAW + 7) / 8) * 8;

	localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_CUR_ZERO  = 2'd1,
		ST_ORIG_ZERO = 2'd2
	} status_t;

	// index 0..11: orig a xyz, orig b xyz, cur a xyz, cur b xyz
	typedef logic [NCRD-1:0][CW-1:0] crd_t;

	typedef struct packed {
		logic [LW-1:0]         l;
		status_t               status;
		logic [CW-1:0]         residual;
		logic [2:0][DW-1:0]    dmag;
		logic [2:0]            dneg;
	} len_t;

	typedef struct packed {
		logic [LW-1:0]         l;
		status_t               status;
		logic [CW-1:0]         residual;
		logic [2:0][DQW-1:0]   um;
		logic [2:0]            sn;
	} dir_t;

	// hess order: xx, yy, zz, xy, xz, yz
	typedef struct packed {
		status_t               status;
		logic [5:0][CW-1:0]    hess;
		logic [CW-1:0]         residual;
		logic [2:0][DIRW-1:0]  dir;
	} res_t;

endpackage
`default_nettype wire

### src/dcgh_len.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcgh_len
// differences, squares and pipelined square roots of the original and the
// current link, one root bit per stage; residual and status at the end
// ----------------------------------------------------------------------------
module dcgh_len (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  dcgh_pkg::crd_t  crd,
	output logic            out_valid,
	output dcgh_pkg::len_t  out
);

	localparam int CW = dcgh_pkg::CW;
	localparam int DW = dcgh_pkg::DW;
	localparam int SW = dcgh_pkg::SW;
	localparam int LW = dcgh_pkg::LW;

	typedef struct packed {
		logic [SW-1:0] n;
		logic [LW:0]   rem;
		logic [LW-1:0] root;
	} sqrt_t;

	typedef struct packed {
		sqrt_t              so;
		sqrt_t              sc;
		logic [2:0][DW-1:0] cmag;
		logic [2:0]         cneg;
	} lstg_t;

	function automatic sqrt_t sqrt_step(input sqrt_t x);
		logic [LW+2:0] rs;
		logic [LW+2:0] tr;
		sqrt_t y;
		rs = {x.rem, x.n[SW-1 -: 2]};
		tr = {1'b0, x.root, 2'b01};
		y.n = {x.n[SW-3:0], 2'b00};
		if (rs >= tr) begin
			y.rem  = (LW+1)'(rs - tr);
			y.root = {x.root[LW-2:0], 1'b1};
		end else begin
			y.rem  = (LW+1)'(rs);
			y.root = {x.root[LW-2:0], 1'b0};
		end
		return y;
	endfunction

	logic [5:0][DW-1:0]   d_c;
	logic [5:0][DW-1:0]   mag_c;
	logic [2:0]           cneg_c;

	logic [5:0][DW-1:0]   mag_s1;
	logic [2:0]           cneg_s1;
	logic [5:0][SW-1:0]   sq_s2;
	logic [2:0][DW-1:0]   cmag_s2;
	logic [2:0]           cneg_s2;
	logic [1:0][SW-1:0]   sum_s3;
	logic [2:0][DW-1:0]   cmag_s3;
	logic [2:0]           cneg_s3;
	lstg_t                rt_s [LW];
	dcgh_pkg::len_t       out_s;

	logic                 v_s1, v_s2, v_s3, v_out;
	logic [LW-1:0]        rt_v;

	lstg_t                rt_in;
	dcgh_pkg::len_t       out_c;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			d_c[i] = {crd[(i < 3) ? i : i + 3][CW-1], crd[(i < 3) ? i : i + 3]}
				- {crd[(i < 3) ? i + 3 : i + 6][CW-1], crd[(i < 3) ? i + 3 : i + 6]};
			mag_c[i] = d_c[i][DW-1] ? -d_c[i] : d_c[i];
		end
		for (int i = 0; i < 3; i++) begin
			cneg_c[i] = d_c[i+3][DW-1];
		end
	end

	always_comb begin
		sqrt_t zo;
		sqrt_t zc;
		zo.n = sum_s3[0];
		zo.rem = '0;
		zo.root = '0;
		zc.n = sum_s3[1];
		zc.rem = '0;
		zc.root = '0;
		rt_in.so = sqrt_step(zo);
		rt_in.sc = sqrt_step(zc);
		rt_in.cmag = cmag_s3;
		rt_in.cneg = cneg_s3;
	end

	// residual l - l0 with saturation, status from the two lengths
	always_comb begin
		logic signed [LW+1:0] rd;
		logic signed [LW+1:0] hi_lim;
		logic signed [LW+1:0] lo_lim;
		logic [LW-1:0]        l0;
		l0 = rt_s[LW-1].so.root;
		out_c.l = rt_s[LW-1].sc.root;
		out_c.dmag = rt_s[LW-1].cmag;
		out_c.dneg = rt_s[LW-1].cneg;
		rd = signed'({2'b00, out_c.l}) - signed'({2'b00, l0});
		hi_lim = (LW+2)'(signed'(dcgh_pkg::SAT_MAX));
		lo_lim = (LW+2)'(signed'(dcgh_pkg::SAT_MIN));
		if (rd > hi_lim) begin
			out_c.residual = dcgh_pkg::SAT_MAX;
		end else if (rd < lo_lim) begin
			out_c.residual = dcgh_pkg::SAT_MIN;
		end else begin
			out_c.residual = CW'(rd);
		end
		if (out_c.l == '0) begin
			out_c.status = dcgh_pkg::ST_CUR_ZERO;
		end else if (l0 == '0) begin
			out_c.status = dcgh_pkg::ST_ORIG_ZERO;
		end else begin
			out_c.status = dcgh_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			rt_v  <= '0;
			v_out <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			rt_v  <= {rt_v[LW-2:0], v_s3};
			v_out <= rt_v[LW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= mag_c;
			cneg_s1 <= cneg_c;
			for (int i = 0; i < 6; i++) begin
				sq_s2[i] <= mag_s1[i] * mag_s1[i];
			end
			cmag_s2 <= mag_s1[5:3];
			cneg_s2 <= cneg_s1;
			sum_s3[0] <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sum_s3[1] <= sq_s2[3] + sq_s2[4] + sq_s2[5];
			cmag_s3 <= cmag_s2;
			cneg_s3 <= cneg_s2;
			rt_s[0] <= rt_in;
			for (int k = 1; k < LW; k++) begin
				rt_s[k].so   <= sqrt_step(rt_s[k-1].so);
				rt_s[k].sc   <= sqrt_step(rt_s[k-1].sc);
				rt_s[k].cmag <= rt_s[k-1].cmag;
				rt_s[k].cneg <= rt_s[k-1].cneg;
			end
			out_s <= out_c;
		end
	end

	assign out_valid = v_out;
	assign out       = out_s;

endmodule
`default_nettype wire

### src/dcgh_dir.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcgh_dir
// unit direction magnitudes |d| * 2^30 / l by restoring division, one
// quotient bit per stage for all three axes
// ----------------------------------------------------------------------------
module dcgh_dir (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  dcgh_pkg::len_t  in,
	output logic            out_valid,
	output dcgh_pkg::dir_t  out
);

	localparam int CW  = dcgh_pkg::CW;
	localparam int LW  = dcgh_pkg::LW;
	localparam int DQW = dcgh_pkg::DQW;

	typedef struct packed {
		logic [LW-1:0]       l;
		dcgh_pkg::status_t   status;
		logic [CW-1:0]       residual;
		logic [2:0]          dneg;
		logic [2:0][LW-1:0]  rem;
		logic [2:0][DQW-1:0] q;
	} dst_t;

	// first step weighs 2^30 with |d| <= l, later steps double the remainder
	function automatic dst_t dir_step(input dst_t x, input logic first);
		logic [LW:0] t;
		dst_t y;
		y = x;
		for (int i = 0; i < 3; i++) begin
			t = first ? {1'b0, x.rem[i]} : {x.rem[i], 1'b0};
			if (t >= {1'b0, x.l}) begin
				y.rem[i] = LW'(t - {1'b0, x.l});
				y.q[i]   = {x.q[i][DQW-2:0], 1'b1};
			end else begin
				y.rem[i] = LW'(t);
				y.q[i]   = {x.q[i][DQW-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	dst_t           ds_s [DQW];
	logic [DQW-1:0] ds_v;
	dst_t           d_in;

	always_comb begin
		d_in.l        = in.l;
		d_in.status   = in.status;
		d_in.residual = in.residual;
		d_in.dneg     = in.dneg;
		d_in.rem      = in.dmag;
		d_in.q        = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ds_v <= '0;
		end else if (adv) begin
			ds_v <= {ds_v[DQW-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ds_s[0] <= dir_step(d_in, 1'b1);
			for (int k = 1; k < DQW; k++) begin
				ds_s[k] <= dir_step(ds_s[k-1], 1'b0);
			end
		end
	end

	always_comb begin
		out.l        = ds_s[DQW-1].l;
		out.status   = ds_s[DQW-1].status;
		out.residual = ds_s[DQW-1].residual;
		out.um       = ds_s[DQW-1].q;
		for (int i = 0; i < 3; i++) begin
			out.sn[i] = ds_s[DQW-1].dneg[i] && (ds_s[DQW-1].q[i] != '0);
		end
	end

	assign out_valid = ds_v[DQW-1];

endmodule
`default_nettype wire

### src/dcgh_hess.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcgh_hess
// hessian numerators from the direction products, division by l one bit per
// stage for the six entries, then saturation into the result register
// ----------------------------------------------------------------------------
module dcgh_hess (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  dcgh_pkg::dir_t  in,
	output logic            out_valid,
	output dcgh_pkg::res_t  out
);

	localparam int CW   = dcgh_pkg::CW;
	localparam int FW   = dcgh_pkg::FW;
	localparam int LW   = dcgh_pkg::LW;
	localparam int DQW  = dcgh_pkg::DQW;
	localparam int DIRW = dcgh_pkg::DIRW;
	localparam int HMW  = dcgh_pkg::HMW;
	localparam int AW   = dcgh_pkg::AW;

	localparam logic [HMW-1:0] ONE = {1'b1, {(HMW-1){1'b0}}};

	typedef struct packed {
		logic [LW-1:0]        l;
		dcgh_pkg::status_t    status;
		logic [CW-1:0]        residual;
		logic [2:0][DIRW-1:0] dir;
		logic [5:0]           hneg;
		logic [5:0][HMW-1:0]  m;
	} mst_t;

	typedef struct packed {
		logic [LW-1:0]        l;
		dcgh_pkg::status_t    status;
		logic [CW-1:0]        residual;
		logic [2:0][DIRW-1:0] dir;
		logic [5:0]           hneg;
		logic [5:0][AW-1:0]   a;
		logic [5:0][LW-1:0]   rem;
		logic [5:0][AW-1:0]   q;
	} hst_t;

	function automatic hst_t hess_step(input hst_t x);
		logic [LW:0] t;
		hst_t y;
		y = x;
		for (int i = 0; i < 6; i++) begin
			t = {x.rem[i], x.a[i][AW-1]};
			y.a[i] = {x.a[i][AW-2:0], 1'b0};
			if (t >= {1'b0, x.l}) begin
				y.rem[i] = LW'(t - {1'b0, x.l});
				y.q[i]   = {x.q[i][AW-2:0], 1'b1};
			end else begin
				y.rem[i] = LW'(t);
				y.q[i]   = {x.q[i][AW-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	mst_t            m_c;
	mst_t            m_s1;
	logic            v_s1;
	hst_t            h_in;
	hst_t            hs_s [AW];
	logic [AW-1:0]   hs_v;
	dcgh_pkg::res_t  r_c;
	dcgh_pkg::res_t  r_out;
	logic            v_out;

	always_comb begin
		logic [2*DQW-1:0] p;
		logic [DIRW-1:0]  uz;
		m_c.l        = in.l;
		m_c.status   = in.status;
		m_c.residual = in.residual;
		for (int i = 0; i < 3; i++) begin
			p = in.um[i] * in.um[i];
			m_c.m[i] = ONE - HMW'(p);
			m_c.hneg[i] = 1'b0;
			uz = DIRW'(in.um[i]);
			m_c.dir[i] = in.sn[i] ? -uz : uz;
		end
		p = in.um[0] * in.um[1];
		m_c.m[3] = HMW'(p);
		m_c.hneg[3] = (in.sn[0] == in.sn[1]) && (p != '0);
		p = in.um[0] * in.um[2];
		m_c.m[4] = HMW'(p);
		m_c.hneg[4] = (in.sn[0] == in.sn[2]) && (p != '0);
		p = in.um[1] * in.um[2];
		m_c.m[5] = HMW'(p);
		m_c.hneg[5] = (in.sn[1] == in.sn[2]) && (p != '0);
	end

	// numerator scaled to coordinate fraction: m * 2^(2F) / 2^60
	always_comb begin
		logic [HMW+2*FW-1:0] w;
		h_in.l        = m_s1.l;
		h_in.status   = m_s1.status;
		h_in.residual = m_s1.residual;
		h_in.dir      = m_s1.dir;
		h_in.hneg     = m_s1.hneg;
		h_in.rem      = '0;
		h_in.q        = '0;
		for (int i = 0; i < 6; i++) begin
			w = {m_s1.m[i], {(2*FW){1'b0}}};
			h_in.a[i] = w[HMW+2*FW-1 -: AW];
		end
	end

	always_comb begin
		logic [CW-1:0] qv;
		r_c.status   = hs_s[AW-1].status;
		r_c.residual = hs_s[AW-1].residual;
		r_c.dir      = hs_s[AW-1].dir;
		for (int i = 0; i < 6; i++) begin
			qv = CW'(hs_s[AW-1].q[i]);
			if ({{CW{1'b0}}, hs_s[AW-1].q[i]} > {{AW{1'b0}}, dcgh_pkg::SAT_MAX}) begin
				r_c.hess[i] = hs_s[AW-1].hneg[i] ? dcgh_pkg::SAT_MIN : dcgh_pkg::SAT_MAX;
			end else begin
				r_c.hess[i] = hs_s[AW-1].hneg[i] ? -qv : qv;
			end
		end
		if (hs_s[AW-1].status != dcgh_pkg::ST_OK) begin
			r_c.hess     = '0;
			r_c.residual = '0;
			r_c.dir      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			hs_v  <= '0;
			v_out <= 1'b0;
		end else if (adv) begin
			v_s1  <= in_valid;
			hs_v  <= {hs_v[AW-2:0], v_s1};
			v_out <= hs_v[AW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1 <= m_c;
			hs_s[0] <= hess_step(h_in);
			for (int k = 1; k < AW; k++) begin
				hs_s[k] <= hess_step(hs_s[k-1]);
			end
			r_out <= r_c;
		end
	end

	assign out_valid = v_out;
	assign out       = r_out;

endmodule
`default_nettype wire

### src/distance_constraint_grad_hessian_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// distance_constraint_grad_hessian_unit
// gradient direction, residual and hessian of a two-node rigid-length link
// ----------------------------------------------------------------------------
// usage:
// - s_t* takes one item per cycle while s_tready is high: twelve signed Q16.16 coordinates, the
//   original a, original b, current a, current b positions, x y z each
// - m_t* gives one result item per input item, in order: direction in Q2.30,
//   residual l - l0 and six hessian entries in Q16.16, status on m_tuser
// - status 1 (current length zero) or 2 (original length zero) comes with
//   all data fields zero
// - from acceptance to m_tvalid an item passes two 33-stage square root
//   pipelines, a 31-stage direction divider and a 33-stage hessian
//   divider, each retiring one bit per stage, plus operand and output stages
// - throughput is one item per cycle while m_tready is high
// - when the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated
// - reset clears only the valid bits; the pipeline is empty afterwards
// ----------------------------------------------------------------------------
module distance_constraint_grad_hessian_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// orig_ax, orig_ay, orig_az, orig_bx, orig_by, orig_bz,
	// cur_ax, cur_ay, cur_az, cur_bx, cur_by, cur_bz
	input  logic [dcgh_pkg::IN_DW-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// dir_x, dir_y, dir_z, residual, hess_xx, hess_yy, hess_zz,
	// hess_xy, hess_xz, hess_yz
	output logic [dcgh_pkg::OUT_DW-1:0] m_tdata,
	// status
	output logic [1:0]                  m_tuser
);

	logic            adv;
	dcgh_pkg::crd_t  crd;
	logic            len_v;
	dcgh_pkg::len_t  len_d;
	logic            dir_v;
	dcgh_pkg::dir_t  dir_d;
	logic            res_v;
	dcgh_pkg::res_t  res;

	// pipeline moves whenever the output register is free or being taken
	assign adv      = m_tready || !res_v;
	assign s_tready = adv;
	assign crd      = s_tdata[dcgh_pkg::NCRD*dcgh_pkg::CW-1:0];

	dcgh_len u_len (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.crd       (crd),
		.out_valid (len_v),
		.out       (len_d)
	);

	dcgh_dir u_dir (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (len_v),
		.in        (len_d),
		.out_valid (dir_v),
		.out       (dir_d)
	);

	dcgh_hess u_hess (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (dir_v),
		.in        (dir_d),
		.out_valid (res_v),
		.out       (res)
	);

	assign m_tvalid = res_v;
	assign m_tdata  = dcgh_pkg::OUT_DW'({res.hess, res.residual, res.dir});
	assign m_tuser  = res.status;

`ifndef SYNTHESIS
	a_zero_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.status != dcgh_pkg::ST_OK) |-> (m_tdata == '0))
		else $error("nonzero data with error status");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.status == dcgh_pkg::ST_OK)
		|-> ($signed(res.dir[0]) <= (1 <<< dcgh_pkg::DFB))
		&& ($signed(res.dir[0]) >= -(1 <<< dcgh_pkg::DFB)))
		else $error("direction beyond unit range");

	a_diag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !res.hess[0][dcgh_pkg::CW-1] && !res.hess[1][dcgh_pkg::CW-1]
		&& !res.hess[2][dcgh_pkg::CW-1])
		else $error("negative hessian diagonal");

	a_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		dir_v && (dir_d.status == dcgh_pkg::ST_OK) |-> (dir_d.l != '0))
		else $error("ok status with zero length");
`endif

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the distance constraint gradient and hessian unit: directed corner
// items, then random links under three idling regimes, all results compared
// in order against an integer predictor of direction, residual and hessian
// ----------------------------------------------------------------------------
module tb;

	localparam int N_RANDOM  = 1080;
	localparam int LATENCY   = 103;
	localparam int MAX_CYC   = 400000;

	typedef struct {
		logic [2:0][31:0]    dir;
		logic [31:0]         residual;
		logic [5:0][31:0]    hess;
		logic [1:0]          status;
	} link_result_t;

	// ---------------------------------------------------------------- predictor
	class link_scoreboard;
		link_result_t pending[$];
		int           n_errors;
		int           n_checked;

		static function logic [127:0] isqrt(logic [127:0] s);
			logic [127:0] r;
			logic [127:0] t;
			r = '0;
			for (int b = 63; b >= 0; b--) begin
				t = r | (128'd1 << b);
				if (t * t <= s) r = t;
			end
			return r;
		endfunction

		static function logic [31:0] hess_entry(logic [127:0] m, logic neg,
				logic [127:0] l);
			logic [127:0] q;
			q = ((m << (2 * dcgh_pkg::FW)) >> 60) / l;
			if (q > 128'h7fffffff) return neg ? dcgh_pkg::SAT_MIN : dcgh_pkg::SAT_MAX;
			return neg ? -q[31:0] : q[31:0];
		endfunction

		function void note_item(logic [dcgh_pkg::NCRD-1:0][dcgh_pkg::CW-1:0] c);
			link_result_t r;
			logic signed [63:0] d[3];
			logic signed [63:0] d0[3];
			logic [127:0]       s, s0, l, l0;
			logic [127:0]       um[3];
			logic [127:0]       mg;
			logic               neg[3];
			logic signed [63:0] res;
			s = '0;
			s0 = '0;
			for (int i = 0; i < 3; i++) begin
				d0[i] = 64'(signed'(c[i])) - 64'(signed'(c[3 + i]));
				d[i] = 64'(signed'(c[6 + i])) - 64'(signed'(c[9 + i]));
				mg = d0[i] < 0 ? 128'(-d0[i]) : 128'(d0[i]);
				s0 += mg * mg;
				mg = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
				s += mg * mg;
			end
			l = isqrt(s);
			l0 = isqrt(s0);
			r.dir = '0;
			r.residual = '0;
			r.hess = '0;
			r.status = dcgh_pkg::ST_OK;
			if (l == 0) r.status = dcgh_pkg::ST_CUR_ZERO;
			else if (l0 == 0) r.status = dcgh_pkg::ST_ORIG_ZERO;
			else begin
				for (int i = 0; i < 3; i++) begin
					mg = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
					um[i] = (mg << 30) / l;
					neg[i] = d[i] < 0 && um[i] != 0;
					r.dir[i] = neg[i] ? -um[i][31:0] : um[i][31:0];
				end
				for (int i = 0; i < 3; i++)
					r.hess[i] = hess_entry((128'd1 << 60) - um[i] * um[i], 1'b0, l);
				r.hess[3] = hess_entry(um[0] * um[1], neg[0] == neg[1] && um[0] * um[1] != 0, l);
				r.hess[4] = hess_entry(um[0] * um[2], neg[0] == neg[2] && um[0] * um[2] != 0, l);
				r.hess[5] = hess_entry(um[1] * um[2], neg[1] == neg[2] && um[1] * um[2] != 0, l);
				res = 64'(l) - 64'(l0);
				if (res > 64'sh7fffffff) res = 64'sh7fffffff;
				if (res < -64'sh80000000) res = -64'sh80000000;
				r.residual = res[31:0];
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [dcgh_pkg::OUT_DW-1:0] data, logic [1:0] user);
			link_result_t e;
			logic [9:0][31:0] got;
			logic [9:0][31:0] want;
			n_checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result data=%h status=%0d", $time, data, user);
				n_errors++;
				return;
			end
			e = pending.pop_front();
			got = data[319:0];
			want = {e.hess, e.residual, e.dir};
			for (int i = 0; i < 10; i++)
				if (got[i] !== want[i]) begin
					$display("%0t: field %0d expected %h actual %h", $time, i, want[i], got[i]);
					n_errors++;
				end
			if (user !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, user);
				n_errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [dcgh_pkg::IN_DW-1:0]    s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [dcgh_pkg::OUT_DW-1:0]   m_tdata;
	logic [1:0]                    m_tuser;

	link_scoreboard      links;
	int                  send_idle_pct;
	int                  recv_idle_pct;
	int                  cycles;
	int                  n_sent;

	distance_constraint_grad_hessian_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) links.check_result(m_tdata, m_tuser);
		if (cycles > MAX_CYC) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	// tvalid stays high after acceptance; the next call or the caller drops it
	task automatic send_link(logic [dcgh_pkg::NCRD-1:0][dcgh_pkg::CW-1:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= dcgh_pkg::IN_DW'(c);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		links.note_item(c);
		n_sent++;
		@(negedge clk);
	endtask

	function automatic logic [dcgh_pkg::CW-1:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return dcgh_pkg::CW'($urandom_range(200)) - dcgh_pkg::CW'(100);
			2: return dcgh_pkg::CW'($urandom_range(40000)) - dcgh_pkg::CW'(20000) << 8;
			default: return $urandom_range(3) == 0 ? dcgh_pkg::SAT_MIN : dcgh_pkg::SAT_MAX;
		endcase
	endfunction

	task automatic send_random_link();
		logic [dcgh_pkg::NCRD-1:0][dcgh_pkg::CW-1:0] c;
		int mode;
		mode = $urandom_range(9);
		for (int i = 0; i < dcgh_pkg::NCRD; i++)
			c[i] = rand_coord(mode < 3 ? 0 : mode < 6 ? 2 : mode < 9 ? 1 : 3);
		// sometimes collapse a length to zero
		if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) c[9 + i] = c[6 + i];
		if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) c[3 + i] = c[i];
		send_link(c);
	endtask

	initial begin
		logic [dcgh_pkg::NCRD-1:0][dcgh_pkg::CW-1:0] c;
		links = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cycles = 0;
		n_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// both lengths zero, current zero, original zero
		send_link('0);
		c = '0; c[0] = 32'h10000; send_link(c);
		c = '0; c[6] = 32'h10000; send_link(c);
		// unit links on each axis and both signs
		for (int a = 0; a < 3; a++) begin
			c = '0; c[a] = 32'h10000; c[6 + a] = 32'h20000; send_link(c);
			c = '0; c[a] = 32'h10000; c[9 + a] = 32'h20000; send_link(c);
		end
		// tiny current length: hessian saturates
		c = '0; c[0] = 32'h10000; c[6] = 1; send_link(c);
		c = '0; c[0] = 32'h10000; c[6] = 1; c[7] = dcgh_pkg::SAT_MIN; c[10] = 1; send_link(c);
		// extreme coordinates
		for (int i = 0; i < dcgh_pkg::NCRD; i++)
			c[i] = (i % 2) ? dcgh_pkg::SAT_MIN : dcgh_pkg::SAT_MAX;
		send_link(c);
		for (int i = 0; i < dcgh_pkg::NCRD; i++)
			c[i] = (i < 3 || (i >= 6 && i < 9)) ? dcgh_pkg::SAT_MAX : dcgh_pkg::SAT_MIN;
		send_link(c);
		c = '0; c[3] = dcgh_pkg::SAT_MIN; c[6] = 1; c[7] = 1; c[8] = 1; send_link(c);
		c = '1; c[9] = 0; send_link(c);
		c = '0; c[0] = 3; c[1] = 4; c[6] = -3; c[7] = 4; c[8] = -12; send_link(c);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 29 : phase == 1 ? 53 : 0;
			recv_idle_pct = phase == 0 ? 53 : phase == 1 ? 29 : 0;
			for (int k = 0; k < N_RANDOM / 3; k++) send_random_link();
		end
		s_tvalid <= 1'b0;

		while (links.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("sent %0d link items, checked %0d results over three idling regimes",
			n_sent, links.n_checked);
		if (links.n_errors == 0 && links.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
